FILE: rtl/cda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cda_pkg
// Shared types and constants for the calendar date add-days block: controller
// states, the command/status structs and the month length lookup.
// ----------------------------------------------------------------------------
package cda_pkg;

   localparam int unsigned YEAR_W  = 16;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned COUNT_W = 20;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
   localparam logic [YEAR_W-1:0] YEAR_RESET = 16'd1;

   // y divisible by 25 <=> (y * inverse(25) mod 2^16) <= floor(65535 / 25)
   localparam logic [YEAR_W-1:0] INV25     = 16'd23593;
   localparam logic [YEAR_W-1:0] DIV25_MAX = 16'd2621;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_ADD  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEAP,
      ST_LOAD,
      ST_WALK,
      ST_DONE
   } cda_state_type;

   typedef struct packed {
      logic capture;        // latch the request fields
      logic leap_en;        // recompute the leap flag
      logic leap_from_load; // leap source: load year instead of stored year
      logic load_check;     // validate and commit a load
      logic walk_step;      // one month step of an add
      logic publish;        // copy the date into the response register
   } cda_cmd_type;

   typedef struct packed {
      logic op_add;
      logic walk_last;
      logic year_wrap;
   } cda_status_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (m) inside
         MONTH_FEB:                               len = leap ? 5'd29 : 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
         default:                                 len = 5'd31;
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/cda_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cda_datapath
// Date registers, operand latch, leap-year unit, month walker and response
// register. Driven by commands from cda_ctrl.
// ----------------------------------------------------------------------------
module cda_datapath (
   input  wire                        clock,
   input  wire                        reset,
   input  cda_pkg::cda_cmd_type       cmd,
   output cda_pkg::cda_status_type    status,
   input  wire                        req_opcode,
   input  wire  [15:0]                req_load_year,
   input  wire  [3:0]                 req_load_month,
   input  wire  [4:0]                 req_load_day,
   input  wire  [19:0]                req_day_count,
   output logic [15:0]                rsp_cur_year,
   output logic [3:0]                 rsp_cur_month,
   output logic [4:0]                 rsp_cur_day,
   output logic                       rsp_bad_date
);
   import cda_pkg::*;

   logic                 op_code_ff,  op_code_in;
   logic [YEAR_W-1:0]    op_year_ff,  op_year_in;
   logic [MONTH_W-1:0]   op_month_ff, op_month_in;
   logic [DAY_W-1:0]     op_day_ff,   op_day_in;
   logic [COUNT_W-1:0]   left_ff,     left_in;
   logic [YEAR_W-1:0]    date_year_ff,  date_year_in;
   logic [MONTH_W-1:0]   date_month_ff, date_month_in;
   logic [DAY_W-1:0]     date_day_ff,   date_day_in;
   logic                 leap_ff, leap_in;
   logic                 bad_ff,  bad_in;
   logic [YEAR_W-1:0]    rsp_year_ff,  rsp_year_in;
   logic [MONTH_W-1:0]   rsp_month_ff, rsp_month_in;
   logic [DAY_W-1:0]     rsp_day_ff,   rsp_day_in;
   logic                 rsp_bad_ff,   rsp_bad_in;

   // leap unit
   logic [YEAR_W-1:0]    leap_year;
   logic [YEAR_W-1:0]    prod;
   logic                 div4, div25, div100, div400, leap_calc;

   // month walker
   logic [DAY_W-1:0]     cur_len, to_end, load_len;
   logic                 walk_last, load_ok;

   always_comb begin
      leap_year = cmd.leap_from_load ? op_year_ff : date_year_ff;
      // low half of the product only
      prod      = leap_year * INV25;
      div4      = (leap_year[1:0] == 2'b00);
      div25     = (prod <= DIV25_MAX);
      div100    = div4 & div25;
      div400    = div100 & (leap_year[3:0] == 4'b0000);
      leap_calc = div400 | (div4 & ~div100);
   end

   always_comb begin
      cur_len   = month_len(date_month_ff, leap_ff);
      to_end    = (date_day_ff <= cur_len) ? (cur_len - date_day_ff) : '0;
      walk_last = (left_ff <= {{(COUNT_W-DAY_W){1'b0}}, to_end});
      load_len  = month_len(op_month_ff, leap_ff);
      load_ok   = (op_month_ff >= MONTH_JAN) && (op_month_ff <= MONTH_DEC) &&
                  (op_day_ff != '0) && (op_day_ff <= load_len);
   end

   always_comb begin
      op_code_in    = op_code_ff;
      op_year_in    = op_year_ff;
      op_month_in   = op_month_ff;
      op_day_in     = op_day_ff;
      left_in       = left_ff;
      date_year_in  = date_year_ff;
      date_month_in = date_month_ff;
      date_day_in   = date_day_ff;
      leap_in       = leap_ff;
      bad_in        = bad_ff;
      rsp_year_in   = rsp_year_ff;
      rsp_month_in  = rsp_month_ff;
      rsp_day_in    = rsp_day_ff;
      rsp_bad_in    = rsp_bad_ff;

      if (cmd.capture) begin
         op_code_in  = req_opcode;
         op_year_in  = req_load_year;
         op_month_in = req_load_month;
         op_day_in   = req_load_day;
         left_in     = req_day_count;
         bad_in      = 1'b0;
      end

      if (cmd.leap_en) begin
         leap_in = leap_calc;
      end

      if (cmd.load_check) begin
         if (load_ok) begin
            date_year_in  = op_year_ff;
            date_month_in = op_month_ff;
            date_day_in   = op_day_ff;
         end else begin
            bad_in = 1'b1;
         end
      end

      if (cmd.walk_step) begin
         if (walk_last) begin
            // remainder fits in the day field here
            date_day_in = date_day_ff + left_ff[DAY_W-1:0];
            left_in     = '0;
         end else begin
            date_day_in = DAY_FIRST;
            left_in     = left_ff - {{(COUNT_W-DAY_W){1'b0}}, to_end} - 1'b1;
            if (date_month_ff >= MONTH_DEC) begin
               date_month_in = MONTH_JAN;
               date_year_in  = date_year_ff + 1'b1;
            end else begin
               date_month_in = date_month_ff + 1'b1;
            end
         end
      end

      if (cmd.publish) begin
         rsp_year_in  = date_year_ff;
         rsp_month_in = date_month_ff;
         rsp_day_in   = date_day_ff;
         rsp_bad_in   = bad_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         date_year_ff  <= YEAR_RESET;
         date_month_ff <= MONTH_JAN;
         date_day_ff   <= DAY_FIRST;
      end else begin
         date_year_ff  <= date_year_in;
         date_month_ff <= date_month_in;
         date_day_ff   <= date_day_in;
      end
   end

   always_ff @(posedge clock) begin
      op_code_ff   <= op_code_in;
      op_year_ff   <= op_year_in;
      op_month_ff  <= op_month_in;
      op_day_ff    <= op_day_in;
      left_ff      <= left_in;
      leap_ff      <= leap_in;
      bad_ff       <= bad_in;
      rsp_year_ff  <= rsp_year_in;
      rsp_month_ff <= rsp_month_in;
      rsp_day_ff   <= rsp_day_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign status.op_add    = (op_code_ff == OP_ADD);
   assign status.walk_last = walk_last;
   assign status.year_wrap = (date_month_ff >= MONTH_DEC);

   assign rsp_cur_year  = rsp_year_ff;
   assign rsp_cur_month = rsp_month_ff;
   assign rsp_cur_day   = rsp_day_ff;
   assign rsp_bad_date  = rsp_bad_ff;

endmodule
`default_nettype wire

FILE: rtl/cda_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cda_ctrl
// Controller for the date block: sequences leap computation, load check and
// the month-by-month walk, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module cda_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   input  cda_pkg::cda_status_type    status,
   output cda_pkg::cda_cmd_type       cmd
);
   import cda_pkg::*;

   cda_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = ~(rsp_valid_ff & rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LEAP;
         end
         ST_LEAP: begin
            state_in = status.op_add ? ST_WALK : ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_DONE;
         end
         ST_WALK: begin
            if (status.walk_last) state_in = ST_DONE;
            else if (status.year_wrap) state_in = ST_LEAP; // new year, refresh leap flag
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
         end
         ST_LEAP: begin
            cmd.leap_en        = 1'b1;
            cmd.leap_from_load = ~status.op_add;
         end
         ST_LOAD: begin
            cmd.load_check = 1'b1;
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
         end
         ST_DONE: begin
            cmd.publish = out_free;
         end
         default: cmd = '0;
      endcase
   end

   assign rsp_valid_in = cmd.publish | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

FILE: rtl/calendar_date_add_days.sv
`default_nettype none
// Sequence: a load computes the leap flag from the load year, then checks and
//   commits the date; an add takes the leap flag of the stored year, then walks.
// The walk steps one month per cycle and returns to the leap state at each year end.
// Throughput: one item at a time; the next transfer is taken once the
//   response register is loaded and the controller is back in idle.
// Reset (synchronous): date = year 1, January 1; no response pending.
// ----------------------------------------------------------------------------
// calendar_date_add_days
// Gregorian date register with checked load and add-days operations.
// ----------------------------------------------------------------------------
module calendar_date_add_days (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire         req_opcode,
   input  wire  [15:0] req_load_year,
   input  wire  [3:0]  req_load_month,
   input  wire  [4:0]  req_load_day,
   input  wire  [19:0] req_day_count,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [15:0] rsp_cur_year,
   output logic [3:0]  rsp_cur_month,
   output logic [4:0]  rsp_cur_day,
   output logic        rsp_bad_date
);
   import cda_pkg::*;

   cda_cmd_type    cmd;
   cda_status_type status;

   cda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cda_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_opcode     (req_opcode),
      .req_load_year  (req_load_year),
      .req_load_month (req_load_month),
      .req_load_day   (req_load_day),
      .req_day_count  (req_day_count),
      .rsp_cur_year   (rsp_cur_year),
      .rsp_cur_month  (rsp_cur_month),
      .rsp_cur_day    (rsp_cur_day),
      .rsp_bad_date   (rsp_bad_date)
   );

   // a transfer always leaves the block busy for the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request side not stalled after a transfer");

   // a response is only produced while an item is in progress
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response raised without an item in progress");

   // a valid response always carries a month in range and a nonzero day
   a_rsp_date_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cur_month >= MONTH_JAN && rsp_cur_month <= MONTH_DEC &&
                     rsp_cur_day != '0))
      else $error("response carries an illegal date");

endmodule
`default_nettype wire
